>>> sv/gwm_pkg.sv
package gwm_pkg;

    localparam int NODE_W       = 6;
    localparam int WEIGHT_W     = 32;
    localparam int RESULT_LIMIT = 32;
    localparam int KEPT_W       = $clog2(RESULT_LIMIT + 1);

    typedef struct packed {
        logic [NODE_W-1:0]          node_a;
        logic [NODE_W-1:0]          node_b;
        logic signed [WEIGHT_W-1:0] weight;
    } edge_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic              load;    // insertion sort step
        logic              shift;   // move one place towards the head
        logic              clear;   // drop all held edges
        logic              kill;    // kill_a / kill_b have just been taken
        logic [NODE_W-1:0] kill_a;
        logic [NODE_W-1:0] kill_b;
    } cell_ctrl_t;

endpackage

>>> sv/greedy_weight_matching.sv
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+---------------------------------------------
// edges    | edge_valid   | edge_stall   | node_a, node_b, edge_weight, last_edge
// matches  | match_valid  | match_stall  | match_a, match_b, match_weight, last_match
//
// Edges are taken one per cycle, while edge_stall is low, into a chain of MAX_EDGES
// insertion-sort cells. After the last edge the chain settles; then it shifts towards the
// head, keeping suitable head edges, until it is empty or 32 matches are kept, and the last
// match is flushed; match_stall can hold a result back. Then edges are taken again.
// Reset empties the chain and the edge count; no clearing pass is needed.
// edge_stall is high from the last edge's transfer until the batch has drained.
module greedy_weight_matching #(
    parameter int MAX_EDGES  = 256,
    parameter int NODE_COUNT = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  edge_valid,
    output logic                                  edge_stall,
    input  logic [gwm_pkg::NODE_W-1:0]            node_a,
    input  logic [gwm_pkg::NODE_W-1:0]            node_b,
    input  logic signed [gwm_pkg::WEIGHT_W-1:0]   edge_weight,
    input  logic                                  last_edge,
    output logic                                  match_valid,
    input  logic                                  match_stall,
    output logic [gwm_pkg::NODE_W-1:0]            match_a,
    output logic [gwm_pkg::NODE_W-1:0]            match_b,
    output logic signed [gwm_pkg::WEIGHT_W-1:0]   match_weight,
    output logic                                  last_match
);
    import gwm_pkg::*;

    localparam int IDX_W = $clog2(MAX_EDGES);

    cell_ctrl_t       cell_ctrl;
    logic             inject_valid;
    logic [IDX_W-1:0] inject_idx;
    edge_t            inject_edge;
    edge_t            match_edge;

    logic             held_valid [MAX_EDGES];
    edge_t            held_edge  [MAX_EDGES];
    logic [IDX_W-1:0] held_idx   [MAX_EDGES];
    logic             held_dead  [MAX_EDGES];
    logic             pass_valid [MAX_EDGES];
    edge_t            pass_edge  [MAX_EDGES];
    logic [IDX_W-1:0] pass_idx   [MAX_EDGES];

    assign inject_edge.node_a = node_a;
    assign inject_edge.node_b = node_b;
    assign inject_edge.weight = edge_weight;

    for (genvar i = 0; i < MAX_EDGES; i++)
    begin : g_cell
        logic             c_in_valid;
        edge_t            c_in_edge;
        logic [IDX_W-1:0] c_in_idx;
        logic             c_nb_valid;
        edge_t            c_nb_edge;
        logic [IDX_W-1:0] c_nb_idx;
        logic             c_nb_dead;

        if (i == 0)
        begin : g_first
            assign c_in_valid = inject_valid;
            assign c_in_edge  = inject_edge;
            assign c_in_idx   = inject_idx;
        end
        else
        begin : g_mid
            assign c_in_valid = pass_valid[i-1];
            assign c_in_edge  = pass_edge[i-1];
            assign c_in_idx   = pass_idx[i-1];
        end

        if (i == MAX_EDGES - 1)
        begin : g_tail
            assign c_nb_valid = 1'b0;
            assign c_nb_edge  = '0;
            assign c_nb_idx   = '0;
            assign c_nb_dead  = 1'b0;
        end
        else
        begin : g_inner
            assign c_nb_valid = held_valid[i+1];
            assign c_nb_edge  = held_edge[i+1];
            assign c_nb_idx   = held_idx[i+1];
            assign c_nb_dead  = held_dead[i+1];
        end

        gwm_cell #(
            .IDX_W(IDX_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .in_valid   (c_in_valid),
            .in_edge    (c_in_edge),
            .in_idx     (c_in_idx),
            .nb_valid   (c_nb_valid),
            .nb_edge    (c_nb_edge),
            .nb_idx     (c_nb_idx),
            .nb_dead    (c_nb_dead),
            .held_valid (held_valid[i]),
            .held_edge  (held_edge[i]),
            .held_idx   (held_idx[i]),
            .held_dead  (held_dead[i]),
            .pass_valid (pass_valid[i]),
            .pass_edge  (pass_edge[i]),
            .pass_idx   (pass_idx[i])
        );
    end

    gwm_ctrl #(
        .MAX_EDGES  (MAX_EDGES),
        .NODE_COUNT (NODE_COUNT)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .edge_valid   (edge_valid),
        .last_edge    (last_edge),
        .edge_stall   (edge_stall),
        .head_valid   (held_valid[0]),
        .head_edge    (held_edge[0]),
        .head_dead    (held_dead[0]),
        .inject_valid (inject_valid),
        .inject_idx   (inject_idx),
        .cell_ctrl    (cell_ctrl),
        .match_stall  (match_stall),
        .match_valid  (match_valid),
        .match_edge   (match_edge),
        .last_match   (last_match)
    );

    assign match_a      = match_edge.node_a;
    assign match_b      = match_edge.node_b;
    assign match_weight = match_edge.weight;

endmodule

>>> sv/gwm_cell.sv
module gwm_cell #(
    parameter int IDX_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gwm_pkg::cell_ctrl_t ctrl,
    input  logic                in_valid,
    input  gwm_pkg::edge_t      in_edge,
    input  logic [IDX_W-1:0]    in_idx,
    input  logic                nb_valid,
    input  gwm_pkg::edge_t      nb_edge,
    input  logic [IDX_W-1:0]    nb_idx,
    input  logic                nb_dead,
    output logic                held_valid,
    output gwm_pkg::edge_t      held_edge,
    output logic [IDX_W-1:0]    held_idx,
    output logic                held_dead,
    output logic                pass_valid,
    output gwm_pkg::edge_t      pass_edge,
    output logic [IDX_W-1:0]    pass_idx
);
    import gwm_pkg::*;

    logic             held_valid_reg, held_valid_next;
    edge_t            held_edge_reg, held_edge_next;
    logic [IDX_W-1:0] held_idx_reg, held_idx_next;
    logic             held_dead_reg, held_dead_next;
    logic             pass_valid_reg, pass_valid_next;
    edge_t            pass_edge_reg, pass_edge_next;
    logic [IDX_W-1:0] pass_idx_reg, pass_idx_next;
    logic             in_first;
    logic             nb_shared;

    // heavier first, later arrival first on a tie
    assign in_first = (in_edge.weight > held_edge_reg.weight) ||
                      ((in_edge.weight == held_edge_reg.weight) && (in_idx > held_idx_reg));

    assign nb_shared = ctrl.kill &&
                       ((nb_edge.node_a == ctrl.kill_a) || (nb_edge.node_a == ctrl.kill_b) ||
                        (nb_edge.node_b == ctrl.kill_a) || (nb_edge.node_b == ctrl.kill_b));

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_edge_next  = held_edge_reg;
        held_idx_next   = held_idx_reg;
        held_dead_next  = held_dead_reg;
        pass_valid_next = 1'b0;
        pass_edge_next  = pass_edge_reg;
        pass_idx_next   = pass_idx_reg;
        if (ctrl.clear)
        begin
            held_valid_next = 1'b0;
        end
        else if (ctrl.load)
        begin
            if (in_valid)
            begin
                if (!held_valid_reg)
                begin
                    held_valid_next = 1'b1;
                    held_edge_next  = in_edge;
                    held_idx_next   = in_idx;
                    held_dead_next  = 1'b0;
                end
                else if (in_first)
                begin
                    held_edge_next  = in_edge;
                    held_idx_next   = in_idx;
                    held_dead_next  = 1'b0;
                    pass_valid_next = 1'b1;
                    pass_edge_next  = held_edge_reg;
                    pass_idx_next   = held_idx_reg;
                end
                else
                begin
                    pass_valid_next = 1'b1;
                    pass_edge_next  = in_edge;
                    pass_idx_next   = in_idx;
                end
            end
        end
        else if (ctrl.shift)
        begin
            held_valid_next = nb_valid;
            held_edge_next  = nb_edge;
            held_idx_next   = nb_idx;
            held_dead_next  = nb_dead || nb_shared;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            pass_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            pass_valid_reg <= pass_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_edge_reg <= held_edge_next;
        held_idx_reg  <= held_idx_next;
        held_dead_reg <= held_dead_next;
        pass_edge_reg <= pass_edge_next;
        pass_idx_reg  <= pass_idx_next;
    end

    assign held_valid = held_valid_reg;
    assign held_edge  = held_edge_reg;
    assign held_idx   = held_idx_reg;
    assign held_dead  = held_dead_reg;
    assign pass_valid = pass_valid_reg;
    assign pass_edge  = pass_edge_reg;
    assign pass_idx   = pass_idx_reg;

endmodule

>>> sv/gwm_ctrl.sv
module gwm_ctrl #(
    parameter int MAX_EDGES  = 256,
    parameter int NODE_COUNT = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          edge_valid,
    input  logic                          last_edge,
    output logic                          edge_stall,
    input  logic                          head_valid,
    input  gwm_pkg::edge_t                head_edge,
    input  logic                          head_dead,
    output logic                          inject_valid,
    output logic [$clog2(MAX_EDGES)-1:0]  inject_idx,
    output gwm_pkg::cell_ctrl_t           cell_ctrl,
    input  logic                          match_stall,
    output logic                          match_valid,
    output gwm_pkg::edge_t                match_edge,
    output logic                          last_match
);
    import gwm_pkg::*;

    localparam int CNT_W = $clog2(MAX_EDGES + 1);
    localparam int IDX_W = $clog2(MAX_EDGES);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_SELECT,
        ST_FLUSH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] wait_reg, wait_next;
    logic [KEPT_W-1:0] kept_reg, kept_next;
    logic             pend_valid_reg, pend_valid_next;
    edge_t            pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    edge_t            out_reg, out_next;
    logic             out_last_reg, out_last_next;

    logic accept;
    logic room;
    logic out_free;
    logic head_ok;

    assign accept   = edge_valid && !edge_stall;
    assign room     = count_reg < CNT_W'(MAX_EDGES);
    assign out_free = !out_valid_reg || !match_stall;
    assign head_ok  = !head_dead && (32'(head_edge.node_a) < NODE_COUNT) &&
                      (32'(head_edge.node_b) < NODE_COUNT);

    assign edge_stall   = (state_reg != ST_LOAD);
    assign inject_valid = accept && room;
    assign inject_idx   = count_reg[IDX_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        wait_next       = wait_reg;
        kept_next       = kept_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && match_stall;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        cell_ctrl       = '0;

        case (state_reg)
            ST_LOAD:
            begin
                cell_ctrl.load = 1'b1;
                if (accept)
                begin
                    if (room)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (last_edge)
                    begin
                        wait_next  = count_next;
                        state_next = ST_SETTLE;
                    end
                end
            end
            ST_SETTLE:
            begin
                // displaced edges ripple down at most one cell per cycle
                cell_ctrl.load = 1'b1;
                if (wait_reg == '0)
                begin
                    kept_next  = '0;
                    state_next = ST_SELECT;
                end
                else
                begin
                    wait_next = wait_reg - 1'b1;
                end
            end
            ST_SELECT:
            begin
                if (!head_valid || (kept_reg == KEPT_W'(RESULT_LIMIT)))
                begin
                    state_next = ST_FLUSH;
                end
                else if (!(head_ok && pend_valid_reg && !out_free))
                begin
                    cell_ctrl.shift = 1'b1;
                    if (head_ok)
                    begin
                        cell_ctrl.kill   = 1'b1;
                        cell_ctrl.kill_a = head_edge.node_a;
                        cell_ctrl.kill_b = head_edge.node_b;
                        pend_valid_next  = 1'b1;
                        pend_next        = head_edge;
                        kept_next        = kept_reg + 1'b1;
                        // a newer keep proves the pending one is not the final one
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                            out_last_next  = 1'b0;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = pend_reg;
                        out_last_next  = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    cell_ctrl.clear = 1'b1;
                    count_next      = '0;
                    state_next      = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            wait_reg       <= '0;
            kept_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            wait_reg       <= wait_next;
            kept_reg       <= kept_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign match_valid = out_valid_reg;
    assign match_edge  = out_reg;
    assign last_match  = out_last_reg;

    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= KEPT_W'(RESULT_LIMIT))
        else $error("kept count beyond result limit");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_EDGES))
        else $error("edge count beyond store size");

    a_no_pend_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> !pend_valid_reg)
        else $error("pending match left over while loading");

    a_match_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && match_stall) |=> (out_valid_reg && $stable(out_reg) &&
                                             $stable(out_last_reg)))
        else $error("stalled match changed");

    a_kill_on_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SELECT && cell_ctrl.kill) |=> pend_valid_reg)
        else $error("kept edge not held as pending");

endmodule
